/* src/ricu_pkg.sv */
package ricu_pkg;

	// Field widths of the instruction word and the result
	localparam int INSTR_W     = 32;
	localparam int OPCODE_W    = 6;
	localparam int REG_FIELD_W = 5;
	localparam int IMM_W       = 10;
	localparam int FUNC_W      = 6;
	localparam int STATUS_W    = 3;
	localparam int VALUE_W     = 21;
	localparam int PROD_W      = 2 * IMM_W;
	localparam int CNT_W       = $clog2(IMM_W);

	// Default sizes of the register file and the history ring
	localparam int VALUE_REG_COUNT_DEF = 22;
	localparam int HISTORY_DEPTH_DEF   = 10;

	// Opcodes
	localparam logic [OPCODE_W-1:0] OP_ALU    = 6'd0;
	localparam logic [OPCODE_W-1:0] OP_STORE  = 6'd1;
	localparam logic [OPCODE_W-1:0] OP_RECALL = 6'd33;

	// ALU function codes
	localparam logic [FUNC_W-1:0] FN_NONE = 6'd0;
	localparam logic [FUNC_W-1:0] FN_ADD  = 6'd32;
	localparam logic [FUNC_W-1:0] FN_SUB  = 6'd34;
	localparam logic [FUNC_W-1:0] FN_MUL  = 6'd24;
	localparam logic [FUNC_W-1:0] FN_DIV  = 6'd26;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK     = 3'd0,
		ST_PAIR   = 3'd1,
		ST_FUNC   = 3'd2,
		ST_OPCODE = 3'd3,
		ST_REG    = 3'd4,
		ST_DIVZ   = 3'd5
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_DECODE,
		S_FETCH,
		S_RUN,
		S_DONE,
		S_RECALL
	} state_t;

	typedef enum logic [1:0] {
		K_REJECT,
		K_STORE,
		K_ALU,
		K_RECALL
	} kind_t;

	typedef struct packed {
		logic [OPCODE_W-1:0]    opcode;
		logic [REG_FIELD_W-1:0] src1;
		logic [REG_FIELD_W-1:0] src2;
		logic [IMM_W-1:0]       imm;
		logic [FUNC_W-1:0]      func;
	} instr_t;

endpackage

/* src/ricu_instr_if.sv */
interface ricu_instr_if import ricu_pkg::*; ();
	logic               valid;
	logic               ready;
	logic [INSTR_W-1:0] instruction;

	modport source (output valid, output instruction, input ready);
	modport sink (input valid, input instruction, output ready);
endinterface

/* src/ricu_result_if.sv */
interface ricu_result_if import ricu_pkg::*; ();
	logic                       valid;
	logic                       ready;
	logic [STATUS_W-1:0]        status;
	logic signed [VALUE_W-1:0]  value;
	logic                       value_valid;

	modport source (output valid, output status, output value, output value_valid, input ready);
	modport sink (input valid, input status, input value, input value_valid, output ready);
endinterface

/* src/register_calculator_instruction_unit_core.sv */
// A store or rejected word is answered from decode, a recall after a history ring read, and
// an ALU word after decode, operand read, 10 bit-serial steps and write-back.
// One item at a time: a new word is taken only once the last result is loaded; the ALU work
// is done by the 10-step bit-serial add/subtract, shift-add multiply and restoring divide unit.
// Asynchronous reset clears the control state and the valid bits of the value registers
// and the history ring, so both read as zero at once; no clearing pass is needed.
module register_calculator_instruction_unit_core import ricu_pkg::*; #(
	parameter int VALUE_REG_COUNT = VALUE_REG_COUNT_DEF,
	parameter int HISTORY_DEPTH   = HISTORY_DEPTH_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	ricu_instr_if.sink    instr,
	ricu_result_if.source result
);

	localparam int RAW = $clog2(VALUE_REG_COUNT);
	localparam int HAW = $clog2(HISTORY_DEPTH);

	state_t state_q, state_d;
	instr_t instr_q;
	kind_t  kind;
	status_t dec_status;

	// Control strobes
	logic in_ready, ld_out, ld_ok;
	logic vreg_we, rd_en, hist_rd_en, rp_we, hist_we, load_ops, step;

	// Value register file
	logic [IMM_W-1:0]           vreg_mem [VALUE_REG_COUNT];
	logic [VALUE_REG_COUNT-1:0] vreg_vld_q;
	logic [RAW-1:0]             sp_q;
	logic [IMM_W-1:0]           rd_a_q, rd_b_q;
	logic                       rd_a_vld_q, rd_b_vld_q;
	logic [IMM_W-1:0]           opa, opb;

	// History ring
	logic [VALUE_W-1:0]       hist_mem [HISTORY_DEPTH];
	logic [HISTORY_DEPTH-1:0] hist_vld_q;
	logic [HAW-1:0]           hwp_q, rp_q, rp_nxt;
	logic [VALUE_W-1:0]       hist_rd_q;
	logic                     hist_rd_vld_q;

	// Bit-serial datapath
	logic [IMM_W-1:0]  opa_q, opb_q;
	logic [PROD_W-1:0] acc_q;
	logic [IMM_W-1:0]  rem_q;
	logic [IMM_W:0]    rem_sh;
	logic              carry_q, divz_q, rem_ge, bx, sum_bit;
	logic [CNT_W-1:0]  cnt_q;
	logic [VALUE_W-1:0] alu_res;

	// Output register
	logic                out_valid_q, vv_q;
	logic [STATUS_W-1:0] status_q;
	logic [VALUE_W-1:0]  value_q;
	status_t             out_status;
	logic [VALUE_W-1:0]  out_value;
	logic                out_vv;

	// Decode and validation
	always_comb begin
		logic fn_ok, regs_ok;
		kind       = K_REJECT;
		dec_status = ST_OK;
		case (instr_q.func)
			FN_ADD, FN_SUB, FN_MUL, FN_DIV: fn_ok = 1'b1;
			default: fn_ok = 1'b0;
		endcase
		regs_ok = (instr_q.src1 != '0) && (instr_q.src1 <= REG_FIELD_W'(VALUE_REG_COUNT - 1))
			&& (instr_q.src2 != '0) && (instr_q.src2 <= REG_FIELD_W'(VALUE_REG_COUNT - 1));
		case (instr_q.opcode)
			OP_ALU: begin
				if (!fn_ok) begin
					dec_status = ST_FUNC;
				end else if (!regs_ok) begin
					dec_status = ST_REG;
				end else begin
					kind = K_ALU;
				end
			end
			OP_STORE, OP_RECALL: begin
				if (instr_q.func != FN_NONE) begin
					dec_status = ST_PAIR;
				end else if (instr_q.src1 != '0 || instr_q.src2 != '0) begin
					dec_status = ST_REG;
				end else if (instr_q.opcode == OP_STORE) begin
					kind = K_STORE;
				end else begin
					kind = K_RECALL;
				end
			end
			default: dec_status = ST_OPCODE;
		endcase
	end

	assign ld_ok = !out_valid_q || result.ready;

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (instr.valid) state_d = S_DECODE;
			end
			S_DECODE: begin
				case (kind)
					K_ALU:    state_d = S_FETCH;
					K_RECALL: state_d = S_RECALL;
					default: begin
						if (ld_ok) state_d = S_IDLE;
					end
				endcase
			end
			S_FETCH: state_d = S_RUN;
			S_RUN: begin
				if (cnt_q == CNT_W'(IMM_W - 1)) state_d = S_DONE;
			end
			S_DONE, S_RECALL: begin
				if (ld_ok) state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	// State outputs
	always_comb begin
		in_ready   = 1'b0;
		ld_out     = 1'b0;
		vreg_we    = 1'b0;
		rd_en      = 1'b0;
		hist_rd_en = 1'b0;
		rp_we      = 1'b0;
		hist_we    = 1'b0;
		load_ops   = 1'b0;
		step       = 1'b0;
		out_status = ST_OK;
		out_value  = '0;
		out_vv     = 1'b0;
		case (state_q)
			S_IDLE: in_ready = 1'b1;
			S_DECODE: begin
				out_status = dec_status;
				case (kind)
					K_ALU: rd_en = 1'b1;
					K_RECALL: begin
						hist_rd_en = 1'b1;
						rp_we      = 1'b1;
					end
					default: begin
						ld_out  = ld_ok;
						vreg_we = ld_ok && (kind == K_STORE);
					end
				endcase
			end
			S_FETCH: load_ops = 1'b1;
			S_RUN:   step = 1'b1;
			S_DONE: begin
				ld_out  = ld_ok;
				hist_we = ld_ok && !divz_q;
				if (divz_q) begin
					out_status = ST_DIVZ;
				end else begin
					out_value = alu_res;
					out_vv    = 1'b1;
				end
			end
			S_RECALL: begin
				ld_out    = ld_ok;
				out_value = hist_rd_vld_q ? hist_rd_q : '0;
				out_vv    = 1'b1;
			end
			default: in_ready = 1'b0;
		endcase
	end

	// Control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			sp_q        <= RAW'(1);
			hwp_q       <= '0;
			rp_q        <= '0;
			vreg_vld_q  <= '0;
			hist_vld_q  <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (vreg_we) begin
				vreg_vld_q[sp_q] <= 1'b1;
				sp_q <= (sp_q == RAW'(VALUE_REG_COUNT - 1)) ? RAW'(1) : sp_q + RAW'(1);
			end
			if (rp_we) rp_q <= rp_nxt;
			if (hist_we) begin
				hist_vld_q[hwp_q] <= 1'b1;
				hwp_q <= (hwp_q == HAW'(HISTORY_DEPTH - 1)) ? '0 : hwp_q + HAW'(1);
			end
			if (ld_out) begin
				out_valid_q <= 1'b1;
			end else if (result.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Recall pointer steps back, or jumps to the newest slot from zero
	always_comb begin
		if (rp_q != '0) begin
			rp_nxt = rp_q - HAW'(1);
		end else if (hwp_q == '0) begin
			rp_nxt = HAW'(HISTORY_DEPTH - 1);
		end else begin
			rp_nxt = hwp_q - HAW'(1);
		end
	end

	// Instruction capture
	always_ff @(posedge clk) begin
		if (in_ready && instr.valid) instr_q <= instr_t'(instr.instruction);
	end

	// Value register file: one write, two registered reads
	always_ff @(posedge clk) begin
		if (vreg_we) vreg_mem[sp_q] <= instr_q.imm;
		if (rd_en) begin
			rd_a_q     <= vreg_mem[instr_q.src1[RAW-1:0]];
			rd_b_q     <= vreg_mem[instr_q.src2[RAW-1:0]];
			rd_a_vld_q <= vreg_vld_q[instr_q.src1[RAW-1:0]];
			rd_b_vld_q <= vreg_vld_q[instr_q.src2[RAW-1:0]];
		end
	end

	assign opa = rd_a_vld_q ? rd_a_q : '0;
	assign opb = rd_b_vld_q ? rd_b_q : '0;

	// History ring: one write, one registered read
	always_ff @(posedge clk) begin
		if (hist_we) hist_mem[hwp_q] <= alu_res;
		if (hist_rd_en) begin
			hist_rd_q     <= hist_mem[rp_nxt];
			hist_rd_vld_q <= hist_vld_q[rp_nxt];
		end
	end

	// Serial step terms
	assign bx      = (instr_q.func == FN_SUB) ? ~opb_q[0] : opb_q[0];
	assign sum_bit = opa_q[0] ^ bx ^ carry_q;
	assign rem_sh  = {rem_q, opa_q[IMM_W-1]};
	assign rem_ge  = rem_sh >= {1'b0, opb_q};

	// Bit-serial datapath, one bit per cycle
	always_ff @(posedge clk) begin
		if (load_ops) begin
			opa_q   <= opa;
			opb_q   <= opb;
			acc_q   <= '0;
			rem_q   <= '0;
			carry_q <= (instr_q.func == FN_SUB);
			cnt_q   <= '0;
			divz_q  <= (instr_q.func == FN_DIV) && (opb == '0);
		end else if (step) begin
			cnt_q <= cnt_q + CNT_W'(1);
			case (instr_q.func)
				FN_MUL: begin
					// MSB-first shift-add
					acc_q <= {acc_q[PROD_W-2:0], 1'b0}
						+ (opb_q[IMM_W-1] ? {{(PROD_W - IMM_W){1'b0}}, opa_q} : '0);
					opb_q <= {opb_q[IMM_W-2:0], 1'b0};
				end
				FN_DIV: begin
					// restoring divide, quotient shifts into opa_q; remainder stays below divisor
					rem_q <= rem_ge ? IMM_W'(rem_sh - {1'b0, opb_q}) : rem_sh[IMM_W-1:0];
					opa_q <= {opa_q[IMM_W-2:0], rem_ge};
				end
				default: begin
					// LSB-first add or subtract with carry flop
					carry_q <= (opa_q[0] & bx) | (opa_q[0] & carry_q) | (bx & carry_q);
					acc_q[IMM_W-1:0] <= {sum_bit, acc_q[IMM_W-1:1]};
					opa_q <= {1'b0, opa_q[IMM_W-1:1]};
					opb_q <= {1'b0, opb_q[IMM_W-1:1]};
				end
			endcase
		end
	end

	// Final ALU value, 21-bit two's complement
	always_comb begin
		case (instr_q.func)
			FN_ADD:  alu_res = VALUE_W'({carry_q, acc_q[IMM_W-1:0]});
			FN_SUB:  alu_res = {{(VALUE_W - IMM_W){~carry_q}}, acc_q[IMM_W-1:0]};
			FN_MUL:  alu_res = VALUE_W'(acc_q);
			FN_DIV:  alu_res = VALUE_W'(opa_q);
			default: alu_res = '0;
		endcase
	end

	// Output item payload
	always_ff @(posedge clk) begin
		if (ld_out) begin
			status_q <= out_status;
			value_q  <= out_value;
			vv_q     <= out_vv;
		end
	end

	assign instr.ready        = in_ready;
	assign result.valid       = out_valid_q;
	assign result.status      = status_q;
	assign result.value       = value_q;
	assign result.value_valid = vv_q;

endmodule

/* sim/tb_register_calculator_instruction_unit_core.sv */
`timescale 1ns / 100ps

module tb_register_calculator_instruction_unit_core import ricu_pkg::*; ();

	localparam int REGS         = VALUE_REG_COUNT_DEF;
	localparam int RING         = HISTORY_DEPTH_DEF;
	localparam int RANDOM_ITEMS = 925;
	localparam int HOLD_AT      = 800;
	localparam int HOLD_CYCLES  = 300;
	localparam int DRAIN_CYCLES = 20;
	localparam int CYCLE_LIMIT  = 400000;

	typedef struct packed {
		status_t            status;
		logic [VALUE_W-1:0] value;
		logic               value_valid;
	} calc_result_t;

	typedef struct {
		logic [INSTR_W-1:0] word;
		bit                 typed;
		calc_result_t       res;
	} stim_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	ricu_instr_if  instr_if ();
	ricu_result_if res_if ();

	register_calculator_instruction_unit_core dut (
		.clk    (clk),
		.arst_n (arst_n),
		.instr  (instr_if.sink),
		.result (res_if.source)
	);

	// Calculator state mirror
	logic [IMM_W-1:0]   calc_regs [REGS];
	logic [VALUE_W-1:0] calc_ring [RING];
	int                 store_ptr;
	int                 ring_wr;
	int                 recall_ptr;

	calc_result_t awaited_results [$];
	stim_row_t    directed_rows [$];

	int fail_count   = 0;
	int results_seen = 0;
	int cycle_count  = 0;
	int tx_idle_pct  = 9;
	int rx_idle_pct  = 85;
	int n_items      = 0;
	int n_stores     = 0;
	int n_alu        = 0;
	int n_recalls    = 0;
	int n_rejected   = 0;

	// 10 ns clock
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic logic [INSTR_W-1:0] pack_word(input logic [OPCODE_W-1:0] op,
			input logic [REG_FIELD_W-1:0] s1, input logic [REG_FIELD_W-1:0] s2,
			input logic [IMM_W-1:0] imm, input logic [FUNC_W-1:0] fn);
		return {op, s1, s2, imm, fn};
	endfunction

	function automatic bit reg_in_range(input logic [REG_FIELD_W-1:0] r);
		return r >= 1 && r <= REGS - 1;
	endfunction

	function automatic void calc_reset();
		foreach (calc_regs[i])
			calc_regs[i] = '0;
		foreach (calc_ring[i])
			calc_ring[i] = '0;
		store_ptr  = 1;
		ring_wr    = 0;
		recall_ptr = 0;
	endfunction

	// Run one instruction against the mirror and return its result
	function automatic calc_result_t calc_execute(input logic [INSTR_W-1:0] word);
		instr_t             f;
		calc_result_t       r;
		logic [IMM_W-1:0]   a;
		logic [IMM_W-1:0]   b;
		logic [VALUE_W-1:0] acc;
		f = instr_t'(word);
		r.status = ST_OK;
		r.value = '0;
		r.value_valid = 1'b0;
		case (f.opcode)
			OP_ALU: begin
				if (f.func != FN_ADD && f.func != FN_SUB && f.func != FN_MUL
						&& f.func != FN_DIV) begin
					r.status = ST_FUNC;
				end else if (!reg_in_range(f.src1) || !reg_in_range(f.src2)) begin
					r.status = ST_REG;
				end else begin
					a = calc_regs[f.src1];
					b = calc_regs[f.src2];
					case (f.func)
						FN_ADD: acc = VALUE_W'(a) + VALUE_W'(b);
						FN_SUB: acc = VALUE_W'(a) - VALUE_W'(b);
						FN_MUL: acc = VALUE_W'(a) * VALUE_W'(b);
						default: acc = (b == '0) ? '0 : VALUE_W'(a / b);
					endcase
					if (f.func == FN_DIV && b == '0) begin
						r.status = ST_DIVZ;
					end else begin
						calc_ring[ring_wr] = acc;
						ring_wr = (ring_wr + 1) % RING;
						r.value = acc;
						r.value_valid = 1'b1;
					end
				end
			end
			OP_STORE, OP_RECALL: begin
				if (f.func != FN_NONE) begin
					r.status = ST_PAIR;
				end else if (f.src1 != '0 || f.src2 != '0) begin
					r.status = ST_REG;
				end else if (f.opcode == OP_STORE) begin
					calc_regs[store_ptr] = f.imm;
					store_ptr = (store_ptr >= REGS - 1) ? 1 : store_ptr + 1;
				end else begin
					// zero pointer jumps to the newest slot, else step back one
					if (recall_ptr == 0)
						recall_ptr = (ring_wr + RING - 1) % RING;
					else
						recall_ptr = recall_ptr - 1;
					r.value = calc_ring[recall_ptr];
					r.value_valid = 1'b1;
				end
			end
			default: r.status = ST_OPCODE;
		endcase
		// tallies for the summary
		n_items++;
		if (r.status != ST_OK)
			n_rejected++;
		else if (f.opcode == OP_STORE)
			n_stores++;
		else if (f.opcode == OP_ALU)
			n_alu++;
		else
			n_recalls++;
		return r;
	endfunction

	// Mostly well-formed instructions, the rest malformed or random
	function automatic logic [INSTR_W-1:0] draw_instruction();
		int                     pick;
		logic [IMM_W-1:0]       imm;
		logic [FUNC_W-1:0]      fn;
		logic [REG_FIELD_W-1:0] s1;
		logic [REG_FIELD_W-1:0] s2;
		logic [OPCODE_W-1:0]    op;
		pick = $urandom_range(0, 99);
		imm = IMM_W'($urandom);
		case ($urandom_range(0, 3))
			0: fn = FN_ADD;
			1: fn = FN_SUB;
			2: fn = FN_MUL;
			default: fn = FN_DIV;
		endcase
		s1 = REG_FIELD_W'($urandom_range(1, REGS - 1));
		s2 = REG_FIELD_W'($urandom_range(1, REGS - 1));
		op = ($urandom_range(0, 1) != 0) ? OP_STORE : OP_RECALL;
		if (pick < 30) begin
			// zero and full-scale operands show up often
			case ($urandom_range(0, 7))
				0: imm = '0;
				1: imm = '1;
				default: ;
			endcase
			return pack_word(OP_STORE, '0, '0, imm, FN_NONE);
		end
		if (pick < 65)
			return pack_word(OP_ALU, s1, s2, imm, fn);
		if (pick < 80)
			return pack_word(OP_RECALL, '0, '0, imm, FN_NONE);
		case ($urandom_range(0, 4))
			0: return $urandom;
			1: begin
				if ($urandom_range(0, 1) != 0)
					s1 = ($urandom_range(0, 1) != 0) ? '0 : REG_FIELD_W'($urandom_range(REGS, 31));
				else
					s2 = ($urandom_range(0, 1) != 0) ? '0 : REG_FIELD_W'($urandom_range(REGS, 31));
				return pack_word(OP_ALU, s1, s2, imm, fn);
			end
			2: return pack_word(op, REG_FIELD_W'($urandom_range(1, 31)),
					REG_FIELD_W'($urandom), imm, FN_NONE);
			3: return pack_word(op, '0, '0, imm, FUNC_W'($urandom_range(1, 63)));
			default: return pack_word(OP_ALU, s1, s2, imm, FUNC_W'($urandom));
		endcase
	endfunction

	function automatic void add_row(input logic [INSTR_W-1:0] word, input bit typed,
			input status_t st, input logic [VALUE_W-1:0] v, input logic vv);
		stim_row_t row;
		row.word = word;
		row.typed = typed;
		row.res.status = st;
		row.res.value = v;
		row.res.value_valid = vv;
		directed_rows.push_back(row);
	endfunction

	// Offer one item, wait for acceptance, then log its expected result
	task automatic send_instruction(input logic [INSTR_W-1:0] word, input bit typed,
			input calc_result_t typed_res);
		calc_result_t pred;
		while ($urandom_range(0, 99) < tx_idle_pct) begin
			instr_if.valid <= 1'b0;
			@(posedge clk);
		end
		instr_if.valid <= 1'b1;
		instr_if.instruction <= word;
		do
			@(posedge clk);
		while (!instr_if.ready);
		pred = calc_execute(word);
		awaited_results.push_back(typed ? typed_res : pred);
	endtask

	// Result sink: checks each item, drives ready, one long hold-off
	initial begin : result_check
		calc_result_t exp;
		int           hold_left;
		bit           hold_done;
		hold_left = 0;
		hold_done = 1'b0;
		res_if.ready = 1'b0;
		forever begin
			@(posedge clk);
			if (arst_n && res_if.valid && res_if.ready) begin
				results_seen++;
				if (awaited_results.size() == 0) begin
					$error("unexpected result item: status %0d value %0d value_valid %0b",
						res_if.status, res_if.value, res_if.value_valid);
					fail_count++;
				end else begin
					exp = awaited_results.pop_front();
					if (res_if.status !== exp.status) begin
						$error("status: expected %0d, got %0d", exp.status, res_if.status);
						fail_count++;
					end
					if (res_if.value !== exp.value) begin
						$error("value: expected %0d, got %0d", $signed(exp.value), res_if.value);
						fail_count++;
					end
					if (res_if.value_valid !== exp.value_valid) begin
						$error("value_valid: expected %0b, got %0b", exp.value_valid,
							res_if.value_valid);
						fail_count++;
					end
				end
			end
			if (!hold_done && results_seen == HOLD_AT) begin
				hold_left = HOLD_CYCLES;
				hold_done = 1'b1;
			end
			if (hold_left > 0) begin
				hold_left--;
				res_if.ready <= 1'b0;
			end else begin
				res_if.ready <= arst_n && ($urandom_range(0, 99) >= rx_idle_pct);
			end
		end
	end

	// Run limit
	initial begin : watchdog
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("Test completed with failures");
		$finish;
	end

	// Stimulus
	initial begin : stimulus
		stim_row_t    row;
		calc_result_t none;
		none = '0;
		instr_if.valid = 1'b0;
		instr_if.instruction = '0;
		calc_reset();

		// Error codes, extremes, every operation, recall walk
		add_row(pack_word(OP_RECALL, '0, '0, '0, FN_NONE), 1, ST_OK, '0, 1'b1);
		add_row('1, 1, ST_OPCODE, '0, 1'b0);
		add_row(pack_word(OP_ALU, 5'd1, 5'd1, '0, 6'h3F), 1, ST_FUNC, '0, 1'b0);
		add_row(pack_word(OP_ALU, 5'd0, 5'd1, '0, FN_ADD), 1, ST_REG, '0, 1'b0);
		add_row(pack_word(OP_ALU, 5'd1, 5'd31, '0, FN_DIV), 1, ST_REG, '0, 1'b0);
		add_row(pack_word(OP_ALU, 5'(REGS), 5'd1, '0, FN_MUL), 1, ST_REG, '0, 1'b0);
		add_row(pack_word(OP_STORE, '0, '0, 10'd5, 6'h3F), 1, ST_PAIR, '0, 1'b0);
		add_row(pack_word(OP_RECALL, '0, '0, '0, 6'd1), 1, ST_PAIR, '0, 1'b0);
		add_row(pack_word(OP_STORE, 5'd31, '0, 10'd5, FN_NONE), 1, ST_REG, '0, 1'b0);
		add_row(pack_word(OP_RECALL, '0, 5'd1, '0, FN_NONE), 1, ST_REG, '0, 1'b0);
		add_row(pack_word(6'd2, '0, '0, '0, FN_NONE), 1, ST_OPCODE, '0, 1'b0);
		add_row(pack_word(OP_STORE, '0, '0, '1, FN_NONE), 1, ST_OK, '0, 1'b0);
		add_row(pack_word(OP_STORE, '0, '0, '0, FN_NONE), 1, ST_OK, '0, 1'b0);
		add_row(pack_word(OP_STORE, '0, '0, 10'd1, FN_NONE), 1, ST_OK, '0, 1'b0);
		add_row(pack_word(OP_ALU, 5'd1, 5'd1, '1, FN_ADD), 0, ST_OK, '0, 1'b0);
		add_row(pack_word(OP_ALU, 5'd2, 5'd1, '0, FN_SUB), 0, ST_OK, '0, 1'b0);
		add_row(pack_word(OP_ALU, 5'd1, 5'd1, '0, FN_MUL), 0, ST_OK, '0, 1'b0);
		add_row(pack_word(OP_ALU, 5'd1, 5'd3, '0, FN_DIV), 0, ST_OK, '0, 1'b0);
		add_row(pack_word(OP_ALU, 5'd1, 5'd2, '0, FN_DIV), 1, ST_DIVZ, '0, 1'b0);
		add_row(pack_word(OP_ALU, 5'(REGS - 1), 5'(REGS - 1), '0, FN_ADD), 0,
			ST_OK, '0, 1'b0);
		add_row(pack_word(OP_RECALL, '0, '0, 10'h2AA, FN_NONE), 0, ST_OK, '0, 1'b0);
		add_row(pack_word(OP_RECALL, '0, '0, '0, FN_NONE), 0, ST_OK, '0, 1'b0);
		add_row(pack_word(OP_RECALL, '0, '0, '0, FN_NONE), 0, ST_OK, '0, 1'b0);
		add_row(pack_word(OP_ALU, 5'd3, 5'd1, 10'h155, FN_DIV), 0, ST_OK, '0, 1'b0);
		add_row(pack_word(OP_STORE, '0, '0, 10'h155, FN_NONE), 1, ST_OK, '0, 1'b0);

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_rows[i]) begin
			row = directed_rows[i];
			send_instruction(row.word, row.typed, row.res);
		end

		// Random part in three idling phases
		for (int i = 0; i < RANDOM_ITEMS; i++) begin
			if (i == RANDOM_ITEMS / 3) begin
				tx_idle_pct = 85;
				rx_idle_pct = 9;
			end else if (i == 2 * RANDOM_ITEMS / 3) begin
				tx_idle_pct = 0;
				rx_idle_pct = 0;
			end
			send_instruction(draw_instruction(), 0, none);
		end
		instr_if.valid <= 1'b0;

		// Drain
		while (awaited_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Ran %0d instruction items (%0d directed): %0d stores, %0d ALU results,",
			n_items, directed_rows.size(), n_stores, n_alu);
		$display("%0d recalls, %0d rejected words; %0d result items checked over %0d cycles.",
			n_recalls, n_rejected, results_seen, cycle_count);
		if (fail_count == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

endmodule
